/* rtl/msa_pkg.sv */
// ----------------------------------------------------------------------------
// msa_pkg
// Types and constants shared by the scan averager controller and datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int CODE_W   = 16;
    localparam int VALUE_W  = 18;
    localparam int GAIN_W   = 24;
    localparam int WINCFG_W = 4;
    localparam int COUNT_W  = 4;
    localparam int SENS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W   = CODE_W + GAIN_W;
    localparam int MAP_W    = PROD_W - 16 + 2;

    localparam int SENSOR_COUNT = 3;

    localparam logic [SENS_W-1:0] SENSOR_RTD1 = 2'd0;
    localparam logic [SENS_W-1:0] SENSOR_RTD2 = 2'd1;
    localparam logic [SENS_W-1:0] SENSOR_LOOP = 2'd2;

    localparam logic [CODE_W-1:0]  CODE_HIGH = 16'd32750;
    localparam logic [CODE_W-1:0]  CODE_LOW  = 16'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 18'sd131071;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = -18'sd131072;

    // Register reset values.
    localparam logic [GAIN_W-1:0]          RTD_GAIN_RST    = 24'd312524;
    localparam logic signed [VALUE_W-1:0]  RTD_OFFSET_RST  = -18'sd66494;
    localparam logic [GAIN_W-1:0]          LOOP_GAIN_RST   = 24'd131072;
    localparam logic signed [VALUE_W-1:0]  LOOP_OFFSET_RST = -18'sd12800;
    localparam logic [WINCFG_W-1:0]        WINDOW_RST      = 4'd4;
    localparam logic [COUNT_W-1:0]         FAULT_LIMIT_RST = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTD_GAIN      = 3'd0,
        CFG_RTD_OFFSET    = 3'd1,
        CFG_LOOP_GAIN     = 3'd2,
        CFG_LOOP_OFFSET   = 3'd3,
        CFG_WINDOW_FIRST  = 3'd4,
        CFG_WINDOW_SECOND = 3'd5,
        CFG_WINDOW_LOOP   = 3'd6,
        CFG_FAULT_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAP,
        ST_READ,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic map;
        logic rd;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic avg_needed;
        logic rd_last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/msa_ram.sv */
// ----------------------------------------------------------------------------
// msa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module msa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/msa_ctrl.sv */
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer of the scan averager: steps one sample through mapping, window
// summation and division when an average falls due, and output hand-off.
// ----------------------------------------------------------------------------
module msa_ctrl
    import msa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = i_sts.avg_needed ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // The last read word is added to the sum in this cycle.
            ST_DRAIN: begin
                n_state = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/msa_dp.sv */
// ----------------------------------------------------------------------------
// msa_dp
// Datapath of the scan averager: configuration registers, code mapping,
// fault counters, sample store, window sum, divider and output register.
// ----------------------------------------------------------------------------
module msa_dp
    import msa_pkg::*;
#(
    parameter int MAX_WINDOW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [CODE_W-1:0]         i_adc_code,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [SENS_W-1:0]         o_sensor_id,
    output logic                      o_average_valid,
    output logic signed [VALUE_W-1:0] o_average_value,
    output logic                      o_fault,
    output logic                      o_switch_channel,
    output logic [SENS_W-1:0]         o_next_sensor
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH  = SENSOR_COUNT * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = VALUE_W + $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(ACC_W);

    // Configuration registers.
    logic [GAIN_W-1:0]         r_rtd_gain;
    logic signed [VALUE_W-1:0] r_rtd_offset;
    logic [GAIN_W-1:0]         r_loop_gain;
    logic signed [VALUE_W-1:0] r_loop_offset;
    logic [WINCFG_W-1:0]       r_win_first;
    logic [WINCFG_W-1:0]       r_win_second;
    logic [WINCFG_W-1:0]       r_win_loop;
    logic [COUNT_W-1:0]        r_fault_limit;

    // Scan state.
    logic [SENS_W-1:0]  r_cur;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_bad [SENSOR_COUNT];
    logic [DEPTH-1:0]   r_valid;
    logic               r_out_valid;

    // Per-sample working registers.
    logic [CODE_W-1:0]         r_code;
    logic [SENS_W-1:0]         r_sid;
    logic [SLOT_W-1:0]         r_sslot;
    logic [WIN_W-1:0]          r_win;
    logic                      r_last;
    logic                      r_fault;
    logic [PROD_W-1:0]         r_prod;
    logic [WIN_W-1:0]          r_rd_cnt;
    logic                      r_rd_pend;
    logic                      r_vld_q;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]          r_quot;
    logic [WIN_W-1:0]          r_rem;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_div_cnt;

    // Output register payload.
    logic [SENS_W-1:0]         r_o_sid;
    logic                      r_o_avg_valid;
    logic signed [VALUE_W-1:0] r_o_avg;
    logic                      r_o_fault;
    logic                      r_o_switch;
    logic [SENS_W-1:0]         r_o_next;

    logic [WINCFG_W-1:0]       win_raw;
    logic [WIN_W-1:0]          win_eff;
    logic                      code_good;
    logic                      r_good;
    logic [COUNT_W-1:0]        n_bad;
    logic [GAIN_W-1:0]         gain_sel;
    logic signed [VALUE_W-1:0] offset_sel;
    logic signed [MAP_W-1:0]   map_sum;
    logic signed [VALUE_W-1:0] map_value;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [ACC_W-1:0]   rd_ext;
    logic [WIN_W:0]            div_trial;
    logic                      div_ge;
    logic [VALUE_W-1:0]        quot_lo;
    logic signed [VALUE_W-1:0] avg_value;
    logic [SENS_W-1:0]         n_cur;

    // Window length of the current sensor; zero acts as one, oversize is clamped.
    always_comb begin
        case (r_cur)
            SENSOR_RTD1: win_raw = r_win_first;
            SENSOR_RTD2: win_raw = r_win_second;
            default:     win_raw = r_win_loop;
        endcase
        if (win_raw == '0) begin
            win_eff = WIN_W'(1);
        end else if (int'(win_raw) > MAX_WINDOW) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(win_raw);
        end
    end

    assign code_good = (r_code <= CODE_HIGH) && (r_code >= CODE_LOW);

    always_comb begin
        if (r_bad[r_sid] < COUNT_MAX) begin
            n_bad = r_bad[r_sid] + COUNT_W'(1);
        end else begin
            n_bad = r_bad[r_sid];
        end
    end

    assign gain_sel   = (r_sid == SENSOR_LOOP) ? r_loop_gain : r_rtd_gain;
    assign offset_sel = (r_sid == SENSOR_LOOP) ? r_loop_offset : r_rtd_offset;

    assign map_sum = signed'({2'b00, r_prod[PROD_W-1:16]}) + MAP_W'(offset_sel);

    always_comb begin
        if (map_sum > MAP_W'(VALUE_MAX)) begin
            map_value = VALUE_MAX;
        end else if (map_sum < MAP_W'(VALUE_MIN)) begin
            map_value = VALUE_MIN;
        end else begin
            map_value = map_sum[VALUE_W-1:0];
        end
    end

    assign n_cur   = (r_sid == SENSOR_LOOP) ? SENSOR_RTD1 : r_sid + SENS_W'(1);
    assign wr_addr = ADDR_W'(r_sid) * ADDR_W'(MAX_WINDOW) + ADDR_W'(r_sslot);
    assign rd_addr = ADDR_W'(r_sid) * ADDR_W'(MAX_WINDOW) + ADDR_W'(r_rd_cnt[SLOT_W-1:0]);

    // Entries never written since reset read as zero.
    assign rd_ext = r_vld_q ? ACC_W'(signed'(rd_data)) : '0;

    assign div_trial = {r_rem, r_quot[ACC_W-1]};
    assign div_ge    = (div_trial >= (WIN_W+1)'(r_win));
    assign quot_lo   = r_quot[VALUE_W-1:0];
    assign avg_value = r_neg ? -signed'(quot_lo) : signed'(quot_lo);

    msa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.map && r_good),
        .i_waddr (wr_addr),
        .i_wdata (map_value),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtd_gain    <= RTD_GAIN_RST;
            r_rtd_offset  <= RTD_OFFSET_RST;
            r_loop_gain   <= LOOP_GAIN_RST;
            r_loop_offset <= LOOP_OFFSET_RST;
            r_win_first   <= WINDOW_RST;
            r_win_second  <= WINDOW_RST;
            r_win_loop    <= WINDOW_RST;
            r_fault_limit <= FAULT_LIMIT_RST;
            r_cur         <= SENSOR_RTD1;
            r_slot        <= '0;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
            r_rd_pend     <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_bad[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RTD_GAIN:      r_rtd_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_RTD_OFFSET:    r_rtd_offset  <= signed'(i_cfg_data[VALUE_W-1:0]);
                    CFG_LOOP_GAIN:     r_loop_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_LOOP_OFFSET:   r_loop_offset <= signed'(i_cfg_data[VALUE_W-1:0]);
                    CFG_WINDOW_FIRST:  r_win_first   <= i_cfg_data[WINCFG_W-1:0];
                    CFG_WINDOW_SECOND: r_win_second  <= i_cfg_data[WINCFG_W-1:0];
                    CFG_WINDOW_LOOP:   r_win_loop    <= i_cfg_data[WINCFG_W-1:0];
                    CFG_FAULT_LIMIT:   r_fault_limit <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.mul) begin
                r_bad[r_sid] <= code_good ? '0 : n_bad;
            end
            if (i_cmd.map) begin
                if (r_good) begin
                    r_valid[wr_addr] <= 1'b1;
                end
                if (r_last) begin
                    r_slot <= '0;
                    r_cur  <= n_cur;
                end else begin
                    r_slot <= r_sslot + SLOT_W'(1);
                    r_cur  <= r_sid;
                end
            end
            r_rd_pend <= i_cmd.rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample payload, sum and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code  <= i_adc_code;
            r_sid   <= r_cur;
            r_sslot <= r_slot;
            r_win   <= win_eff;
            r_last  <= (int'(r_slot) + 1 >= int'(win_eff));
        end
        if (i_cmd.mul) begin
            r_prod  <= PROD_W'(r_code) * PROD_W'(gain_sel);
            r_good  <= code_good;
            r_fault <= !code_good && (n_bad > r_fault_limit);
        end
        if (i_cmd.map) begin
            r_acc    <= '0;
            r_rd_cnt <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_cnt <= r_rd_cnt + WIN_W'(1);
            r_vld_q  <= r_valid[rd_addr];
        end
        if (r_rd_pend) begin
            r_acc <= r_acc + rd_ext;
        end
        if (i_cmd.div_init) begin
            r_neg     <= r_acc[ACC_W-1];
            r_quot    <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        // Restoring division, one quotient bit per cycle.
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + CNT_W'(1);
            r_quot    <= {r_quot[ACC_W-2:0], div_ge};
            r_rem     <= div_ge ? WIN_W'(div_trial - (WIN_W+1)'(r_win))
                                : div_trial[WIN_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_sid       <= r_sid;
            r_o_avg_valid <= r_good && r_last;
            r_o_avg       <= (r_good && r_last) ? avg_value : '0;
            r_o_fault     <= r_fault;
            r_o_switch    <= r_last;
            r_o_next      <= r_cur;
        end
    end

    assign o_sts.avg_needed = r_good && r_last;
    assign o_sts.rd_last    = (r_rd_cnt == r_win - WIN_W'(1));
    assign o_sts.div_done   = (r_div_cnt == CNT_W'(ACC_W - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_sensor_id      = r_o_sid;
    assign o_average_valid  = r_o_avg_valid;
    assign o_average_value  = r_o_avg;
    assign o_fault          = r_o_fault;
    assign o_switch_channel = r_o_switch;
    assign o_next_sensor    = r_o_next;

endmodule

/* rtl/multi_sensor_scan_averager.sv */
// ----------------------------------------------------------------------------
// multi_sensor_scan_averager
// Round-robin averager for two RTD inputs and one 4-20 mA loop input.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one ADC code for the sensor named by
// the previous result's o_next_sensor (sensor 0 after reset). Every input
// transaction yields exactly one output transaction holding the sensor id,
// the fault flag, the window-end flag with the next sensor and, at a window
// end with a good code, the window average.
// Flow: a sample that closes no average passes through load, multiply, map
// and hand-off; the next sample is accepted once the block is back in idle.
// A sample that closes a window with a good code also passes through the
// window sum and the divider: the sum reads the w stored slots of the window
// (w being the window length) one slot per cycle, and the divider retires
// one quotient bit per cycle. One sample is in work at a time.
// Reset (synchronous, active low) restores the register defaults, selects
// sensor 0, clears the fault counters and marks every stored slot as zero.
// A result waits in the output register while i_out_stall is high; the next
// sample is still accepted and processed, and holds only at its hand-off.
// Configuration writes are always taken (o_cfg_ready is tied high).
// ----------------------------------------------------------------------------
module multi_sensor_scan_averager
    import msa_pkg::*;
#(
    parameter int MAX_WINDOW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CODE_W-1:0]         i_adc_code,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SENS_W-1:0]         o_sensor_id,
    output logic                      o_average_valid,
    output logic signed [VALUE_W-1:0] o_average_value,
    output logic                      o_fault,
    output logic                      o_switch_channel,
    output logic [SENS_W-1:0]         o_next_sensor
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    msa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msa_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_adc_code       (i_adc_code),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_sensor_id      (o_sensor_id),
        .o_average_valid  (o_average_valid),
        .o_average_value  (o_average_value),
        .o_fault          (o_fault),
        .o_switch_channel (o_switch_channel),
        .o_next_sensor    (o_next_sensor)
    );

`ifndef ASSERT_OFF
    // An average is only published at the end of a window.
    a_avg_at_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_average_valid |-> o_switch_channel)
        else $error("average published without a channel switch");

    // A bad sample never carries an average.
    a_fault_no_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault |-> !o_average_valid)
        else $error("fault and average reported together");

    // Without a window end the sensor selection stays put.
    a_same_sensor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_switch_channel |-> o_next_sensor == o_sensor_id)
        else $error("sensor changed inside a window");

    // Once a sample is accepted the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second sample accepted while one is in work");
`endif

endmodule
